>>> design/lqm_pkg.sv
`default_nettype none
package lqm_pkg;

  localparam int WINDOW = 100;
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int FRAC_W = 16;
  localparam int LOSS_W = FRAC_W + 1;
  localparam int STEP_W = $clog2(FRAC_W);

  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_AUTH   = 2'd1;
  localparam logic [1:0] OP_REPLAY = 2'd2;
  localparam logic [1:0] OP_RTT    = 2'd3;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic        send_ok;
    logic [15:0] rtt_sample;
  } in_item_t;

  typedef struct packed {
    logic [16:0] loss_rate;
    logic [6:0]  window_fill;
    logic [15:0] fail_streak;
    logic [15:0] srtt;
    logic [15:0] auth_failures;
    logic [15:0] replays_seen;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [LOSS_W-1:0] quot;
  } div_stat_t;

endpackage
`default_nettype wire

>>> design/lqm_div.sv
`default_nettype none
// Fractional divider: quot = (num << FRAC_W) / den, num <= den, zero when den is zero; one bit per cycle.
module lqm_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire [lqm_pkg::CNT_W-1:0] num,
  input  wire [lqm_pkg::CNT_W-1:0] den,
  output lqm_pkg::div_stat_t     stat
);
  import lqm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic [LOSS_W-1:0] quot_r, quot_nxt;
  logic [CNT_W:0]    rem2;
  logic [CNT_W:0]    diff;
  logic              take;

  // shared shift / compare / subtract
  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, den};
  assign take = (rem2 >= {1'b0, den});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    quot_nxt = quot_r;
    if (start) begin
      if (den == '0) begin
        quot_nxt = '0;
        done_nxt = 1'b1;
      end else if (num == den) begin
        quot_nxt = {1'b1, {FRAC_W{1'b0}}};
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = '0;
        rem_nxt  = num;
        q_nxt    = '0;
      end
    end else if (busy_r) begin
      rem_nxt  = take ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
      q_nxt    = {q_r[FRAC_W-2:0], take};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(FRAC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quot_nxt = {1'b0, q_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    quot_r <= quot_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule
`default_nettype wire

>>> design/link_quality_metrics_unit.sv
`default_nettype none
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_stall  | in_data  (lqm_pkg::in_item_t)
// out     | out | out_valid / out_stall| out_data (lqm_pkg::out_item_t)
//
// Each item runs accept, update, divider start, 16 divider steps, divider done
// and result load before the next accept; the serial divider sets the pace.
// No sends yet or every held send lost: the divider answers at once, no steps.
// Reset clears all counters; the ring is read on each accept, used only when full.
// in_stall is high while an item is at work; a result waits in the output register
// while the next beat enters, and the next result holds the block until it is free.
module link_quality_metrics_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  lqm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output lqm_pkg::out_item_t out_data
);
  import lqm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_UPD   = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  in_item_t          item_r;
  logic              ring_q_r;
  logic              ring_mem [WINDOW];
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  succ_r, succ_nxt;
  logic [15:0]       streak_r, streak_nxt;
  logic [15:0]       rtt_r, rtt_nxt;
  logic [15:0]       auth_r, auth_nxt;
  logic [15:0]       replay_r, replay_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic              accept;
  logic              full;
  logic [18:0]       rtt_sum;
  logic [CNT_W+6:0]  fill_ext;
  div_stat_t         div_st;
  logic              quot_ok_r, quot_ok_nxt;
  logic [LOSS_W-1:0] quot_r, quot_nxt;
  logic              load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign full     = (fill_r == CNT_W'(WINDOW));
  assign rtt_sum  = {rtt_r, 3'b000} - {3'b000, rtt_r} + {3'b000, item_r.rtt_sample};
  assign fill_ext = {7'd0, fill_r};

  lqm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_START),
    .num   (fill_r - succ_r),
    .den   (fill_r),
    .stat  (div_st)
  );

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    fill_nxt   = fill_r;
    succ_nxt   = succ_r;
    streak_nxt = streak_r;
    rtt_nxt    = rtt_r;
    auth_nxt   = auth_r;
    replay_nxt = replay_r;
    out_valid_nxt = load || (out_valid_r && out_stall);
    out_nxt    = out_r;
    if (load) begin
      out_nxt.loss_rate     = quot_r;
      out_nxt.window_fill   = fill_ext[6:0];
      out_nxt.fail_streak   = streak_r;
      out_nxt.srtt          = rtt_r;
      out_nxt.auth_failures = auth_r;
      out_nxt.replays_seen  = replay_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_START;
        unique case (item_r.operation)
          OP_SEND: begin
            // evict the overwritten outcome once the window is full
            succ_nxt = succ_r - CNT_W'(full && ring_q_r && (succ_r != '0))
                     + CNT_W'(item_r.send_ok);
            if (!full) fill_nxt = fill_r + 1'b1;
            ptr_nxt = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
            if (item_r.send_ok) streak_nxt = '0;
            else if (streak_r != CNT_MAX) streak_nxt = streak_r + 1'b1;
          end
          OP_AUTH: begin
            if (auth_r != CNT_MAX) auth_nxt = auth_r + 1'b1;
          end
          OP_REPLAY: begin
            if (replay_r != CNT_MAX) replay_nxt = replay_r + 1'b1;
          end
          OP_RTT: begin
            rtt_nxt = (rtt_r == '0) ? item_r.rtt_sample : rtt_sum[18:3];
          end
          default: ;
        endcase
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // leave once the quotient is known and the output register takes it
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // divider result capture and completion tracking
  always_comb begin
    quot_ok_nxt = quot_ok_r;
    quot_nxt    = quot_r;
    if (state_r == ST_START) quot_ok_nxt = 1'b0;
    if (div_st.done) begin
      quot_ok_nxt = 1'b1;
      quot_nxt    = div_st.quot;
    end
  end

  assign load = (state_r == ST_DIV) && quot_ok_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      succ_r      <= '0;
      streak_r    <= '0;
      rtt_r       <= '0;
      auth_r      <= '0;
      replay_r    <= '0;
      out_valid_r <= 1'b0;
      quot_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      succ_r      <= succ_nxt;
      streak_r    <= streak_nxt;
      rtt_r       <= rtt_nxt;
      auth_r      <= auth_nxt;
      replay_r    <= replay_nxt;
      out_valid_r <= out_valid_nxt;
      quot_ok_r   <= quot_ok_nxt;
    end
    quot_r <= quot_nxt;
    out_r  <= out_nxt;
  end

  // outcome ring: read on accept, written during the update of a send
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_data;
      ring_q_r <= ring_mem[ptr_r];
    end
    if (state_r == ST_UPD && item_r.operation == OP_SEND) begin
      ring_mem[ptr_r] <= item_r.send_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_succ_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    succ_r <= fill_r) else $error("success count above fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW)) else $error("fill count above window");

  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_UPD) else $error("accepted beat not updated");

  a_load_quot: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> quot_ok_r && (state_r == ST_DIV)) else $error("result loaded early");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == ST_DIV) else $error("divider done out of sequence");

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import lqm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  link_quality_metrics_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  int        errors = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  logic      rx_hold = 1'b0;
  out_item_t pending_metrics[$];

  // shadow state of the link statistics
  bit          outcome_hist [WINDOW];
  int unsigned hist_ptr = 0;
  int unsigned fill_cnt = 0;
  int unsigned succ_cnt = 0;
  int unsigned streak = 0;
  int unsigned rtt_avg = 0;
  int unsigned auth_cnt = 0;
  int unsigned replay_cnt = 0;

  function automatic int unsigned sat_inc(int unsigned v);
    return (v >= 32'(CNT_MAX)) ? 32'(CNT_MAX) : v + 1;
  endfunction

  function automatic out_item_t update_link_metrics(in_item_t ev);
    out_item_t   m;
    int unsigned lost;
    case (ev.operation)
      OP_SEND: begin
        // full window: the outcome being overwritten leaves the success count
        if (fill_cnt >= WINDOW) begin
          if (outcome_hist[hist_ptr] && succ_cnt > 0) succ_cnt--;
        end else begin
          fill_cnt++;
        end
        outcome_hist[hist_ptr] = ev.send_ok;
        if (ev.send_ok) succ_cnt++;
        hist_ptr = (hist_ptr + 1 >= WINDOW) ? 0 : hist_ptr + 1;
        streak = ev.send_ok ? 0 : sat_inc(streak);
      end
      OP_AUTH:   auth_cnt = sat_inc(auth_cnt);
      OP_REPLAY: replay_cnt = sat_inc(replay_cnt);
      default: begin
        if (rtt_avg == 0) rtt_avg = 32'(ev.rtt_sample);
        else rtt_avg = (rtt_avg * 7 + 32'(ev.rtt_sample)) / 8;
      end
    endcase
    lost = (succ_cnt <= fill_cnt) ? fill_cnt - succ_cnt : 0;
    m.loss_rate     = (fill_cnt == 0) ? '0 : 17'((lost << 16) / fill_cnt);
    m.window_fill   = 7'(fill_cnt);
    m.fail_streak   = 16'(streak);
    m.srtt          = 16'(rtt_avg);
    m.auth_failures = 16'(auth_cnt);
    m.replays_seen  = 16'(replay_cnt);
    return m;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want) report_error($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // input beats feed the shadow model; output beats are checked in order
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_metrics.push_back(update_link_metrics(in_data));
      if (out_valid && !out_stall) begin
        if (pending_metrics.size() == 0) begin
          report_error("result beat with no pending event");
        end else begin
          want = pending_metrics.pop_front();
          compare_field("loss_rate", out_data.loss_rate, want.loss_rate);
          compare_field("window_fill", 17'(out_data.window_fill), 17'(want.window_fill));
          compare_field("fail_streak", 17'(out_data.fail_streak), 17'(want.fail_streak));
          compare_field("srtt", 17'(out_data.srtt), 17'(want.srtt));
          compare_field("auth_failures", 17'(out_data.auth_failures),
                        17'(want.auth_failures));
          compare_field("replays_seen", 17'(out_data.replays_seen),
                        17'(want.replays_seen));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function automatic in_item_t mk(logic [1:0] op, logic ok, logic [15:0] rtt);
    in_item_t it;
    it.operation  = op;
    it.send_ok    = ok;
    it.rtt_sample = rtt;
    return it;
  endfunction

  function automatic in_item_t random_event(int ok_pct);
    in_item_t it;
    int       pick;
    it.send_ok    = 1'($urandom_range(1));
    it.rtt_sample = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 50) it.operation = OP_SEND;
    else if (pick < 62) it.operation = OP_AUTH;
    else if (pick < 74) it.operation = OP_REPLAY;
    else it.operation = OP_RTT;
    if (it.operation == OP_SEND) it.send_ok = ($urandom_range(99) < ok_pct);
    // small samples let the average drain back to zero now and then
    if (it.operation == OP_RTT && $urandom_range(3) == 0)
      it.rtt_sample = 16'($urandom_range(7));
    return it;
  endfunction

  // valid is only lowered when a gap is inserted, never re-raised in the same step
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (send_idle_pct > 0 && $urandom_range(9) == 0) gap += $urandom_range(25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  task automatic test_directed();
    send_item(mk(OP_REPLAY, 1'b1, 16'hFFFF));  // no sends yet
    send_item(mk(OP_AUTH, 1'b0, 16'h0000));
    send_item(mk(OP_RTT, 1'b0, 16'h0000));     // zero average loads zero
    send_item(mk(OP_RTT, 1'b1, 16'h0001));
    send_item(mk(OP_RTT, 1'b0, 16'h0000));     // 7/8 truncates back to zero
    send_item(mk(OP_RTT, 1'b0, 16'hFFFF));     // loaded directly again
    send_item(mk(OP_RTT, 1'b1, 16'h0000));
    send_item(mk(OP_RTT, 1'b0, 16'hFFFF));
    send_item(mk(OP_SEND, 1'b0, 16'hFFFF));    // single loss: full-scale loss rate
    send_item(mk(OP_SEND, 1'b0, 16'h5555));
    send_item(mk(OP_SEND, 1'b1, 16'hAAAA));
    send_item(mk(OP_AUTH, 1'b1, 16'hFFFF));
    send_item(mk(OP_REPLAY, 1'b0, 16'hAAAA));
    send_item(mk(OP_SEND, 1'b1, 16'h0000));
    send_item(mk(OP_SEND, 1'b1, 16'hFFFF));
    send_item(mk(OP_RTT, 1'b1, 16'h8000));
    send_item(mk(OP_SEND, 1'b0, 16'h0001));
    send_item(mk(OP_REPLAY, 1'b1, 16'h0000));
    send_item(mk(OP_AUTH, 1'b0, 16'h7FFF));
    send_item(mk(OP_RTT, 1'b0, 16'h0003));
  endtask

  // walk past a full window with all-good, then all-lost, then mixed outcomes
  task automatic test_window_wrap();
    repeat (120) send_item(mk(OP_SEND, 1'b1, 16'($urandom_range(16'hFFFF))));
    repeat (110) send_item(mk(OP_SEND, 1'b0, 16'($urandom_range(16'hFFFF))));
    repeat (30) send_item(mk(OP_SEND, 1'($urandom_range(1)),
                             16'($urandom_range(16'hFFFF))));
  endtask

  task automatic test_random(int n);
    int ok_pct;
    ok_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: ok_pct = 0;
          1: ok_pct = 100;
          default: ok_pct = $urandom_range(100);
        endcase
      end
      send_item(random_event(ok_pct));
    end
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (30) send_item(random_event(50));
    join
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(0, 0);
    test_directed();
    test_window_wrap();
    test_random(400);
    set_idling(71, 0);
    test_random(400);
    set_idling(0, 71);
    test_random(400);
    set_idling(7, 7);
    test_random(400);
    test_backpressure();
    finish_run();
  end

endmodule

>>> sim.f
design/lqm_pkg.sv
design/lqm_div.sv
design/link_quality_metrics_unit.sv
tb/tb.sv
